// ----- hdl/gregorian_days_between_dates_defines.svh -----
// ----------------------------------------------------------------------------
// gregorian_days_between_dates_defines.svh
// Assertion macros shared by the date counter.
// ----------------------------------------------------------------------------
`ifndef GREGORIAN_DAYS_BETWEEN_DATES_DEFINES_SVH
`define GREGORIAN_DAYS_BETWEEN_DATES_DEFINES_SVH

// Condition that must hold at every clock edge out of reset.
`define GDBD_ASSERT(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Trigger in one cycle implies a consequence in the next.
`define GDBD_ASSERT_NEXT(lbl, trig, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cons)) \
		else $error(msg);

`endif

// ----- hdl/gdbd_pkg.sv -----
// ----------------------------------------------------------------------------
// gdbd_pkg
// Types, constants and calendar helpers for the date counter.
// ----------------------------------------------------------------------------
package gdbd_pkg;

	localparam int DAY_W   = 5;
	localparam int MONTH_W = 4;
	localparam int YEAR_W  = 14;
	localparam int COUNT_W = 22;
	localparam int R400_W  = 9;

	localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
	localparam logic [YEAR_W-1:0]  YEAR_CYCLE = YEAR_W'(400);
	localparam logic [R400_W-1:0]  R400_LAST  = R400_W'(399);
	localparam logic [MONTH_W-1:0] MONTH_DEC  = MONTH_W'(12);
	localparam logic [MONTH_W-1:0] MONTH_JAN  = MONTH_W'(1);
	localparam logic [DAY_W-1:0]   DAY_FIRST  = DAY_W'(1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RED_S,
		ST_RED_E,
		ST_CHECK,
		ST_STEP,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic load;
		logic red_s;
		logic red_e;
		logic check;
		logic step;
		logic fin;
	} ctrl_t;

	typedef struct packed {
		logic rem_ge;
		logic dates_ok;
		logic cur_lt_end;
	} status_t;

	// Leap year from the year reduced mod 400.
	function automatic logic leap_r400(input logic [R400_W-1:0] r);
		leap_r400 = (r[1:0] == 2'd0) && (r != R400_W'(100)) && (r != R400_W'(200))
			&& (r != R400_W'(300));
	endfunction

	// Month length; 0 for a month code that is not a month.
	function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
			input logic leap);
		unique case (m)
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: month_len = DAY_W'(31);
			4'd4, 4'd6, 4'd9, 4'd11:                    month_len = DAY_W'(30);
			4'd2:    month_len = leap ? DAY_W'(29) : DAY_W'(28);
			default: month_len = '0;
		endcase
	endfunction

	function automatic logic date_ok(input logic [DAY_W-1:0] d,
			input logic [MONTH_W-1:0] m, input logic [R400_W-1:0] r);
		logic [DAY_W-1:0] len;
		len = month_len(m, leap_r400(r));
		date_ok = (len != '0) && (d != '0) && (d <= len);
	endfunction

endpackage

// ----- hdl/gdbd_if.sv -----
// ----------------------------------------------------------------------------
// gdbd_if
// Valid/ready channels for date pairs in and day counts out.
// ----------------------------------------------------------------------------
interface gdbd_req_if
	import gdbd_pkg::*;
();
	logic               valid;
	logic               ready;
	logic [DAY_W-1:0]   start_day;
	logic [MONTH_W-1:0] start_month;
	logic [YEAR_W-1:0]  start_year;
	logic [DAY_W-1:0]   end_day;
	logic [MONTH_W-1:0] end_month;
	logic [YEAR_W-1:0]  end_year;
	logic               include_end_day;

	modport source (output valid, start_day, start_month, start_year, end_day, end_month,
		end_year, include_end_day, input ready);
	modport sink (input valid, start_day, start_month, start_year, end_day, end_month,
		end_year, include_end_day, output ready);
endinterface

interface gdbd_rsp_if
	import gdbd_pkg::*;
();
	logic               valid;
	logic               ready;
	logic [COUNT_W-1:0] day_count;
	logic               invalid_date;

	modport source (output valid, day_count, invalid_date, input ready);
	modport sink (input valid, day_count, invalid_date, output ready);
endinterface

// ----- hdl/gregorian_days_between_dates.sv -----
// ----------------------------------------------------------------------------
// gregorian_days_between_dates
// Counts Gregorian days from a start date to an end date by day stepping.
// ----------------------------------------------------------------------------
// Channel  Dir  Fields
// req      in   start/end day, month, year; include_end_day
// rsp      out  day_count, invalid_date
//
// After a transaction on req, the start year and then the end year are reduced
// mod 400, the dates are checked, and the day stepper runs one day per cycle
// up to the end date; invalid dates skip the stepping.
// The two years are first reduced mod 400 on one shared subtractor.
// req.ready is high only while idle; a finished result waits in the output
// register, and a next result waits in the sequencer until that one is taken.
// arst_n clears the sequencer and the output valid.
// ----------------------------------------------------------------------------
`include "gregorian_days_between_dates_defines.svh"

module gregorian_days_between_dates
	import gdbd_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	gdbd_req_if.sink  req,
	gdbd_rsp_if.source rsp
);

	ctrl_t   ctrl;
	status_t status;
	state_t  state;

	gdbd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.status    (status),
		.ctrl      (ctrl),
		.state     (state)
	);

	gdbd_dpath u_dpath (
		.clk             (clk),
		.ctrl            (ctrl),
		.status          (status),
		.start_day       (req.start_day),
		.start_month     (req.start_month),
		.start_year      (req.start_year),
		.end_day         (req.end_day),
		.end_month       (req.end_month),
		.end_year        (req.end_year),
		.include_end_day (req.include_end_day),
		.day_count       (rsp.day_count),
		.invalid_date    (rsp.invalid_date)
	);

	`GDBD_ASSERT(a_invalid_zero, !(rsp.valid && rsp.invalid_date) || (rsp.day_count == '0),
		"invalid date with nonzero count")
	`GDBD_ASSERT_NEXT(a_busy_after_accept, req.valid && req.ready, !req.ready,
		"ready again right after accept")
	`GDBD_ASSERT_NEXT(a_fin_loads_out, ctrl.fin, rsp.valid && (state == ST_IDLE),
		"result not presented after finish")

endmodule

// ----- hdl/gdbd_ctrl.sv -----
// ----------------------------------------------------------------------------
// gdbd_ctrl
// Sequencer: year reduction, validity check, day stepping, result hand-off.
// ----------------------------------------------------------------------------
module gdbd_ctrl
	import gdbd_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    req_valid,
	output logic    req_ready,
	output logic    rsp_valid,
	input  logic    rsp_ready,
	input  status_t status,
	output ctrl_t   ctrl,
	output state_t  state
);

	state_t state_q, state_d;
	logic   out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctrl.fin)
				out_valid_q <= 1'b1;
			else if (rsp_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		state_d   = state_q;
		ctrl      = '0;
		req_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					ctrl.load = 1'b1;
					state_d   = ST_RED_S;
				end
			end
			ST_RED_S: begin
				ctrl.red_s = 1'b1;
				if (!status.rem_ge)
					state_d = ST_RED_E;
			end
			ST_RED_E: begin
				ctrl.red_e = 1'b1;
				if (!status.rem_ge)
					state_d = ST_CHECK;
			end
			ST_CHECK: begin
				ctrl.check = 1'b1;
				state_d    = status.dates_ok ? ST_STEP : ST_FIN;
			end
			ST_STEP: begin
				ctrl.step = 1'b1;
				if (!status.cur_lt_end)
					state_d = ST_FIN;
			end
			ST_FIN: begin
				// wait until the output register is free
				if (!out_valid_q || rsp_ready) begin
					ctrl.fin = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign rsp_valid = out_valid_q;
	assign state     = state_q;

endmodule

// ----- hdl/gdbd_dpath.sv -----
// ----------------------------------------------------------------------------
// gdbd_dpath
// Date registers, mod-400 subtractor, day stepper and result register.
// ----------------------------------------------------------------------------
module gdbd_dpath
	import gdbd_pkg::*;
(
	input  logic               clk,
	input  ctrl_t              ctrl,
	output status_t            status,
	input  logic [DAY_W-1:0]   start_day,
	input  logic [MONTH_W-1:0] start_month,
	input  logic [YEAR_W-1:0]  start_year,
	input  logic [DAY_W-1:0]   end_day,
	input  logic [MONTH_W-1:0] end_month,
	input  logic [YEAR_W-1:0]  end_year,
	input  logic               include_end_day,
	output logic [COUNT_W-1:0] day_count,
	output logic               invalid_date
);

	logic [DAY_W-1:0]   cd_q, ed_q;
	logic [MONTH_W-1:0] cm_q, em_q;
	logic [YEAR_W-1:0]  cy_q, ey_q, rem_q;
	logic [R400_W-1:0]  cr_q, er_q;
	logic               inc_q, bad_q;
	logic [COUNT_W-1:0] cnt_q, cnt_out_q;
	logic               bad_out_q;

	logic [YEAR_W-1:0]  rem_sub;
	logic [DAY_W-1:0]   cur_len;
	logic               cnt_full;

	assign rem_sub  = rem_q - YEAR_CYCLE;
	assign cur_len  = month_len(cm_q, leap_r400(cr_q));
	assign cnt_full = (cnt_q == COUNT_MAX);

	assign status.rem_ge     = (rem_q >= YEAR_CYCLE);
	assign status.dates_ok   = date_ok(cd_q, cm_q, cr_q) && date_ok(ed_q, em_q, er_q);
	assign status.cur_lt_end = {cy_q, cm_q, cd_q} < {ey_q, em_q, ed_q};

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			cd_q  <= start_day;
			cm_q  <= start_month;
			cy_q  <= start_year;
			ed_q  <= end_day;
			em_q  <= end_month;
			ey_q  <= end_year;
			inc_q <= include_end_day;
			rem_q <= start_year;
			cnt_q <= '0;
			bad_q <= 1'b0;
		end
		if (ctrl.red_s || ctrl.red_e) begin
			if (status.rem_ge) begin
				rem_q <= rem_sub;
			end else if (ctrl.red_s) begin
				cr_q  <= rem_q[R400_W-1:0];
				rem_q <= ey_q;
			end else begin
				er_q <= rem_q[R400_W-1:0];
			end
		end
		if (ctrl.check)
			bad_q <= !status.dates_ok;
		if (ctrl.step) begin
			if (status.cur_lt_end) begin
				if (!cnt_full)
					cnt_q <= cnt_q + COUNT_W'(1);
				if (cd_q == cur_len) begin
					cd_q <= DAY_FIRST;
					if (cm_q == MONTH_DEC) begin
						cm_q <= MONTH_JAN;
						cy_q <= cy_q + YEAR_W'(1);
						cr_q <= (cr_q == R400_LAST) ? '0 : cr_q + R400_W'(1);
					end else begin
						cm_q <= cm_q + MONTH_W'(1);
					end
				end else begin
					cd_q <= cd_q + DAY_W'(1);
				end
			end else if (!cnt_full) begin
				cnt_q <= cnt_q + COUNT_W'(inc_q);
			end
		end
		if (ctrl.fin) begin
			cnt_out_q <= bad_q ? '0 : cnt_q;
			bad_out_q <= bad_q;
		end
	end

	assign day_count    = cnt_out_q;
	assign invalid_date = bad_out_q;

endmodule

// ----- bench/gregorian_days_between_dates_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gregorian_days_between_dates_tb
// Checks the day counter against a closed-form calendar predictor: directed
// calendar corners, receiver hold-off, a drain pause, then random date pairs.
// ----------------------------------------------------------------------------
module gregorian_days_between_dates_tb;
	import gdbd_pkg::*;

	typedef struct packed {
		logic [DAY_W-1:0]   start_day;
		logic [MONTH_W-1:0] start_month;
		logic [YEAR_W-1:0]  start_year;
		logic [DAY_W-1:0]   end_day;
		logic [MONTH_W-1:0] end_month;
		logic [YEAR_W-1:0]  end_year;
		logic               include_end_day;
	} date_pair_t;

	typedef struct packed {
		logic [COUNT_W-1:0] day_count;
		logic               invalid_date;
	} day_span_t;

	localparam int unsigned YEAR_TOP        = 16383;
	localparam int unsigned RANDOM_ITEMS    = 70;
	localparam int unsigned HOLD_OFF_CYCLES = 800;

	logic clk;
	logic arst_n;

	gdbd_req_if req_ch();
	gdbd_rsp_if rsp_ch();

	gregorian_days_between_dates dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	day_span_t   expected_spans[$];
	int unsigned mismatches   = 0;
	bit          steady       = 1'b0;   // no idling on either side
	int unsigned hold_request = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#1_000_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	function automatic bit is_leap(int unsigned y);
		return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
	endfunction

	// 0 for a month code that is not a month
	function automatic int unsigned month_length(int unsigned m, int unsigned y);
		case (m)
			4, 6, 9, 11: return 30;
			2:           return is_leap(y) ? 29 : 28;
			default:     return (m >= 1 && m <= 12) ? 31 : 0;
		endcase
	endfunction

	function automatic bit real_date(int unsigned d, int unsigned m, int unsigned y);
		return (d != 0) && (d <= month_length(m, y));
	endfunction

	// day number with 1 January of year 0 as day 1 (year 0 is leap)
	function automatic int unsigned ordinal(int unsigned d, int unsigned m, int unsigned y);
		int unsigned n;
		n = 365 * y + (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400;
		for (int unsigned i = 1; i < m; i++)
			n += month_length(i, y);
		return n + d;
	endfunction

	function automatic day_span_t predict_span(date_pair_t p);
		day_span_t   r;
		int unsigned a, b, n;
		r = '0;
		if (!real_date(p.start_day, p.start_month, p.start_year) ||
				!real_date(p.end_day, p.end_month, p.end_year)) begin
			r.invalid_date = 1'b1;
			return r;
		end
		a = ordinal(p.start_day, p.start_month, p.start_year);
		b = ordinal(p.end_day, p.end_month, p.end_year);
		n = (a < b) ? b - a : 0;
		n += p.include_end_day;
		r.day_count = (n > COUNT_MAX) ? COUNT_MAX : COUNT_W'(n);
		return r;
	endfunction

	function automatic date_pair_t make_pair(int unsigned sd, int unsigned sm, int unsigned sy,
			int unsigned ed, int unsigned em, int unsigned ey, int unsigned inc);
		date_pair_t p;
		p.start_day       = DAY_W'(sd);
		p.start_month     = MONTH_W'(sm);
		p.start_year      = YEAR_W'(sy);
		p.end_day         = DAY_W'(ed);
		p.end_month       = MONTH_W'(em);
		p.end_year        = YEAR_W'(ey);
		p.include_end_day = inc[0];
		return p;
	endfunction

	// span of at most a few weeks inside one month
	function automatic date_pair_t short_pair();
		int unsigned y, m;
		y = $urandom_range(YEAR_TOP);
		m = $urandom_range(1, 12);
		return make_pair($urandom_range(1, 14), m, y, $urandom_range(15, 28), m, y,
			$urandom_range(1));
	endfunction

	task automatic send_dates(date_pair_t p);
		while (!steady && $urandom_range(99) < 19) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid           <= 1'b1;
		req_ch.start_day       <= p.start_day;
		req_ch.start_month     <= p.start_month;
		req_ch.start_year      <= p.start_year;
		req_ch.end_day         <= p.end_day;
		req_ch.end_month       <= p.end_month;
		req_ch.end_year        <= p.end_year;
		req_ch.include_end_day <= p.include_end_day;
		do @(posedge clk); while (!req_ch.ready);
		expected_spans.push_back(predict_span(p));
	endtask

	// result checker and receiver-side flow control
	initial begin : receiver
		int unsigned hold_left;
		day_span_t   want;
		hold_left    = 0;
		rsp_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (expected_spans.size() == 0) begin
					$display("%0t: unexpected transaction, day_count %0d invalid_date %0b",
						$time, rsp_ch.day_count, rsp_ch.invalid_date);
					mismatches++;
				end else begin
					want = expected_spans.pop_front();
					if (rsp_ch.day_count !== want.day_count) begin
						$display("%0t: day_count expected %0d, got %0d",
							$time, want.day_count, rsp_ch.day_count);
						mismatches++;
					end
					if (rsp_ch.invalid_date !== want.invalid_date) begin
						$display("%0t: invalid_date expected %0b, got %0b",
							$time, want.invalid_date, rsp_ch.invalid_date);
						mismatches++;
					end
				end
			end
			if (hold_request != 0) begin
				hold_left    = hold_request;
				hold_request = 0;
			end
			if (hold_left != 0) begin
				hold_left--;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= steady || ($urandom_range(99) >= 19);
			end
		end
	end

	task automatic test_calendar_corners;
		send_dates(make_pair(1, 1, 1, 2, 1, 1, 0));
		send_dates(make_pair(15, 6, 2024, 15, 6, 2024, 0));      // same date
		send_dates(make_pair(15, 6, 2024, 15, 6, 2024, 1));
		send_dates(make_pair(31, 12, 9999, 1, 1, 1, 1));         // start after end
		send_dates(make_pair(31, 12, YEAR_TOP, 1, 1, 0, 0));
		send_dates(make_pair(29, 2, 0, 1, 3, 0, 0));             // year 0 is leap
		send_dates(make_pair(29, 2, 1900, 1, 3, 1900, 0));       // century, not leap
		send_dates(make_pair(28, 2, 1900, 1, 3, 1900, 1));
		send_dates(make_pair(29, 2, 2000, 1, 3, 2000, 0));       // 400th year, leap
		send_dates(make_pair(28, 2, 2100, 1, 3, 2100, 0));
		send_dates(make_pair(0, 5, 2020, 1, 6, 2020, 1));        // day zero
		send_dates(make_pair(1, 0, 2020, 1, 6, 2020, 0));        // month zero
		send_dates(make_pair(1, 1, 2020, 1, 13, 2020, 1));
		send_dates(make_pair(1, 15, 2020, 31, 15, 2020, 0));
		send_dates(make_pair(31, 4, 2021, 1, 5, 2021, 0));       // day past month end
		send_dates(make_pair(1, 1, 2021, 31, 9, 2021, 0));       // bad end date only
		send_dates(make_pair(31, 1, 2023, 1, 2, 2023, 0));
		send_dates(make_pair(31, 12, 1999, 1, 1, 2000, 1));
		send_dates(make_pair(1, 1, 2000, 1, 1, 2001, 0));
		send_dates(make_pair(1, 1, 1600, 1, 1, 2000, 0));        // one full 400-year cycle
		send_dates(make_pair(1, 3, YEAR_TOP - 1, 31, 12, YEAR_TOP, 1));
		send_dates(make_pair(1, 1, 0, 1, 1, 11490, 1));          // count saturates
	endtask

	// receiver stalls while the sender keeps offering, so req backs up
	task automatic test_output_hold_off;
		hold_request = HOLD_OFF_CYCLES;
		repeat (6)
			send_dates(short_pair());
	endtask

	task automatic test_drain_pause;
		req_ch.valid <= 1'b0;
		do @(posedge clk); while (expected_spans.size() != 0);
		repeat (3)
			send_dates(short_pair());
	endtask

	task automatic test_random_dates;
		int unsigned kind, pick, sy, ey, sd, sm, ed, em;
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			steady = (i >= 40 && i < 60);
			kind = $urandom_range(99);
			pick = $urandom_range(99);
			// bias some start years onto century boundaries
			sy = ($urandom_range(4) == 0) ? 100 * $urandom_range(YEAR_TOP / 100)
				: $urandom_range(YEAR_TOP);
			ey = sy + ((pick < 85) ? $urandom_range(3)
				: (pick < 95) ? $urandom_range(4, 20) : $urandom_range(21, 60));
			if (ey > YEAR_TOP)
				ey = YEAR_TOP;
			sm = $urandom_range(1, 12);
			sd = $urandom_range(1, month_length(sm, sy));
			em = $urandom_range(1, 12);
			ed = $urandom_range(1, month_length(em, ey));
			if ($urandom_range(3) == 0)
				sd = month_length(sm, sy);
			if (kind < 70) begin
				send_dates(make_pair(sd, sm, sy, ed, em, ey, $urandom_range(1)));
			end else if (kind < 80) begin
				send_dates(make_pair(ed, em, ey, sd, sm, sy, $urandom_range(1)));
			end else if (kind < 85) begin
				send_dates(make_pair(sd, sm, sy, sd, sm, sy, $urandom_range(1)));
			end else begin
				send_dates(make_pair($urandom_range(31), $urandom_range(15), sy,
					$urandom_range(31), $urandom_range(15), ey, $urandom_range(1)));
			end
		end
		steady = 1'b0;
	endtask

	initial begin
		arst_n                 = 1'b0;
		req_ch.valid           = 1'b0;
		req_ch.start_day       = '0;
		req_ch.start_month     = '0;
		req_ch.start_year      = '0;
		req_ch.end_day         = '0;
		req_ch.end_month       = '0;
		req_ch.end_year        = '0;
		req_ch.include_end_day = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_calendar_corners();
		test_output_hold_off();
		test_drain_pause();
		test_random_dates();

		req_ch.valid <= 1'b0;
		do @(posedge clk); while (expected_spans.size() != 0);
		repeat (100) @(posedge clk);
		if (mismatches == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
